// ===== rtl/core/tdf_pkg.sv =====
package tdf_pkg;

  // Width of the input value field and of the factor result field.
  localparam int unsigned ValueFieldWidth  = 16;
  localparam int unsigned FactorFieldWidth = 16;

  // Most results that one request may produce; further factors are dropped.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntWidth   = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NONE,
    ST_TWOS,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DECIDE,
    ST_LAST_FACTOR,
    ST_FLUSH
  } state_e;

endpackage

// ===== rtl/core/tdf_in_if.sv =====
interface tdf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [tdf_pkg::ValueFieldWidth-1:0]     value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/tdf_out_if.sv =====
interface tdf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [tdf_pkg::FactorFieldWidth-1:0]    factor;
  logic                                    has_factor;
  logic                                    last;

  modport source (output valid, output factor, output has_factor, output last, input ready);
  modport sink   (input valid, input factor, input has_factor, input last, output ready);
endinterface

// ===== rtl/core/trial_division_factorizer.sv =====
// Trial-division prime factorizer.
// A request on req_i carries one unsigned value; its low VALUE_WIDTH bits are factored.
// The results leave on res_o in ascending order, one prime factor per result, repeated
// factors repeated, and the final result of a request has last set. Values zero and one
// give a single result with has_factor low, factor zero and last set.
// Factors of two are shifted out first. Every division pass then runs the same steps,
// whether it tries a new odd divisor or divides out a factor that was just found
// again: a load step, one quotient bit per cycle from the bit-serial restoring divider
// and a decision step. A 16-bit prime therefore takes about 128 passes, while a value
// built from small factors finishes far sooner.
// The divider is the only division unit and is shared by the bound test and the
// divisibility test: d*d <= n holds exactly when d <= n / d.
// A new request is taken only when the previous one has been fully worked off; the last
// result may still sit in the output register while the next request is accepted.
// When the receiver stalls, the block holds one pending factor and one result in the
// output register and then waits; nothing is lost or reordered.
// Reset is asynchronous and active low; it empties the output register and returns the
// controller to idle, ready for a request as soon as reset is released.
module trial_division_factorizer #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tdf_in_if.sink           req_i,
  tdf_out_if.source        res_o
);

  localparam int unsigned W   = VALUE_WIDTH;
  // A trial divisor never exceeds 2^ceil(W/2) + 1, so this width leaves headroom.
  localparam int unsigned DW  = (W + 1) / 2 + 1;
  localparam int unsigned BCW = $clog2(W + 1);
  localparam int unsigned CW  = tdf_pkg::CntWidth;
  localparam int unsigned FW  = tdf_pkg::FactorFieldWidth;

  tdf_pkg::state_e state_q, state_d;

  // Remaining value, current odd trial divisor and factor bookkeeping.
  logic [W-1:0]   n_q, n_d;
  logic [DW-1:0]  d_q, d_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]   pend_q, pend_d;
  logic           pend_vld_q, pend_vld_d;

  // Bit-serial divider: the dividend shifts out at the top while quotient bits shift in.
  logic [W-1:0]   div_q, div_d;
  logic [DW-1:0]  prem_q, prem_d;
  logic [BCW-1:0] bit_cnt_q, bit_cnt_d;

  // Output register.
  logic           out_vld_q, out_vld_d;
  logic [FW-1:0]  out_factor_q, out_factor_d;
  logic           out_has_q, out_has_d;
  logic           out_last_q, out_last_d;

  logic           slot_free;
  logic           push_ok;
  logic           push_req;
  logic [W-1:0]   push_val;
  logic           cnt_room;
  logic [31:0]    value_ext;
  logic [W-1:0]   n_in;
  logic [31:0]    pend_ext;
  logic [DW:0]    trial_rem;
  logic [DW:0]    trial_diff;

  assign value_ext = 32'(req_i.value);
  assign n_in      = value_ext[W-1:0];
  assign pend_ext  = 32'(pend_q);

  assign slot_free = !out_vld_q || res_o.ready;
  // A new factor may be taken when there is no pending one to move out, or it can move.
  assign push_ok   = !pend_vld_q || slot_free;
  assign cnt_room  = cnt_q < CW'(tdf_pkg::MaxResults);

  // One restoring step: bring down the next dividend bit and try the subtraction.
  assign trial_rem  = {prem_q, div_q[W-1]};
  assign trial_diff = trial_rem - {1'b0, d_q};

  assign res_o.valid      = out_vld_q;
  assign res_o.factor     = out_factor_q;
  assign res_o.has_factor = out_has_q;
  assign res_o.last       = out_last_q;

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    d_d          = d_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    div_d        = div_q;
    prem_d       = prem_q;
    bit_cnt_d    = bit_cnt_q;
    out_vld_d    = out_vld_q && !res_o.ready;
    out_factor_d = out_factor_q;
    out_has_d    = out_has_q;
    out_last_d   = out_last_q;
    push_req     = 1'b0;
    push_val     = '0;
    req_i.ready  = 1'b0;

    case (state_q)
      tdf_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          n_d        = n_in;
          cnt_d      = '0;
          pend_vld_d = 1'b0;
          state_d    = (n_in < W'(2)) ? tdf_pkg::ST_NONE : tdf_pkg::ST_TWOS;
        end
      end
      tdf_pkg::ST_NONE: begin
        if (slot_free) begin
          out_vld_d    = 1'b1;
          out_factor_d = '0;
          out_has_d    = 1'b0;
          out_last_d   = 1'b1;
          state_d      = tdf_pkg::ST_IDLE;
        end
      end
      tdf_pkg::ST_TWOS: begin
        if (!n_q[0] && cnt_room) begin
          push_req = 1'b1;
          push_val = W'(2);
          if (push_ok) begin
            n_d = n_q >> 1;
          end
        end else begin
          d_d     = DW'(3);
          state_d = tdf_pkg::ST_DIV_LOAD;
        end
      end
      tdf_pkg::ST_DIV_LOAD: begin
        if (cnt_room) begin
          div_d     = n_q;
          prem_d    = '0;
          bit_cnt_d = BCW'(W);
          state_d   = tdf_pkg::ST_DIV;
        end else begin
          state_d = tdf_pkg::ST_LAST_FACTOR;
        end
      end
      tdf_pkg::ST_DIV: begin
        if (trial_rem >= {1'b0, d_q}) begin
          prem_d = trial_diff[DW-1:0];
          div_d  = {div_q[W-2:0], 1'b1};
        end else begin
          prem_d = trial_rem[DW-1:0];
          div_d  = {div_q[W-2:0], 1'b0};
        end
        bit_cnt_d = bit_cnt_q - BCW'(1);
        if (bit_cnt_q == BCW'(1)) begin
          state_d = tdf_pkg::ST_DECIDE;
        end
      end
      tdf_pkg::ST_DECIDE: begin
        // The quotient falling below the divisor means d*d exceeds the remaining value.
        if (div_q < W'(d_q)) begin
          state_d = tdf_pkg::ST_LAST_FACTOR;
        end else if (prem_q == '0) begin
          push_req = 1'b1;
          push_val = W'(d_q);
          if (push_ok) begin
            n_d     = div_q;
            state_d = tdf_pkg::ST_DIV_LOAD;
          end
        end else begin
          d_d     = d_q + DW'(2);
          state_d = tdf_pkg::ST_DIV_LOAD;
        end
      end
      tdf_pkg::ST_LAST_FACTOR: begin
        if (n_q > W'(2) && cnt_room) begin
          push_req = 1'b1;
          push_val = n_q;
          if (push_ok) begin
            state_d = tdf_pkg::ST_FLUSH;
          end
        end else begin
          state_d = tdf_pkg::ST_FLUSH;
        end
      end
      tdf_pkg::ST_FLUSH: begin
        if (slot_free) begin
          out_vld_d    = 1'b1;
          out_factor_d = pend_ext[FW-1:0];
          out_has_d    = 1'b1;
          out_last_d   = 1'b1;
          pend_vld_d   = 1'b0;
          state_d      = tdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdf_pkg::ST_IDLE;
      end
    endcase

    // A factor is held back in the pending register so that the last one can carry the last flag.
    if (push_req && push_ok) begin
      if (pend_vld_q) begin
        out_vld_d    = 1'b1;
        out_factor_d = pend_ext[FW-1:0];
        out_has_d    = 1'b1;
        out_last_d   = 1'b0;
      end
      pend_d     = push_val;
      pend_vld_d = 1'b1;
      cnt_d      = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tdf_pkg::ST_IDLE;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      bit_cnt_q  <= '0;
      n_q        <= '0;
      d_q        <= '0;
    end else begin
      state_q    <= state_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      n_q        <= n_d;
      d_q        <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    div_q        <= div_d;
    prem_q       <= prem_d;
    out_factor_q <= out_factor_d;
    out_has_q    <= out_has_d;
    out_last_q   <= out_last_d;
  end

endmodule

// ===== bench/trial_division_factorizer_test.sv =====
`timescale 1ns / 1ps

// Stand-alone bench for the trial-division factorizer.
// Each request carries one 16-bit value. Each result carries one prime factor
// or none, with has_factor and last. A behavioral factorizer in this module
// predicts the results of every accepted request that has no hand-written
// outcome. The monitor then checks the results in order, field by field.
module trial_division_factorizer_test;

  // Each odd trial divisor takes a full division pass. The largest 16-bit
  // prime needs about 128 of them, so a single request can keep the block busy
  // through its whole search with no handshake on either side. The watchdog
  // limit below is set well above such a search plus the long output hold.
  localparam int unsigned QuietLimit   = 20000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned TailCycles   = 64;
  localparam int unsigned RandomValues = 106;
  localparam int unsigned CalmValues   = 20;
  localparam int unsigned NumDirected  = 24;
  localparam int unsigned NumCrowding  = 4;

  typedef struct packed {
    logic [tdf_pkg::FactorFieldWidth-1:0] factor;
    logic                                 has_factor;
    logic                                 last;
  } factor_result_t;

  // One row of the directed table. Where typed_in is set, the single result is
  // written out by hand. Every other row is checked against the predictor.
  typedef struct packed {
    logic [tdf_pkg::ValueFieldWidth-1:0] value;
    logic                                typed_in;
    factor_result_t                      outcome;
  } vector_t;

  localparam factor_result_t NoResult = '{factor: '0, has_factor: 1'b0, last: 1'b0};

  // The rows cover the field extremes and values below two, which give one
  // result with no factor. They also cover repeated odd factors such as 27 and
  // 729, and squares of primes, where the search stops exactly at d*d == n.
  // The longest run of results at this width (2**15) and the largest 16-bit
  // prime, which takes the longest search, are included as well.
  vector_t directed_vectors [0:NumDirected-1] = '{
    '{16'd0,     1'b1, '{16'd0,     1'b0, 1'b1}},
    '{16'd1,     1'b1, '{16'd0,     1'b0, 1'b1}},
    '{16'd2,     1'b1, '{16'd2,     1'b1, 1'b1}},
    '{16'd3,     1'b1, '{16'd3,     1'b1, 1'b1}},
    '{16'd65521, 1'b1, '{16'd65521, 1'b1, 1'b1}},
    '{16'd65535, 1'b0, NoResult},
    '{16'd65534, 1'b0, NoResult},
    '{16'd32768, 1'b0, NoResult},
    '{16'd27,    1'b0, NoResult},
    '{16'd729,   1'b0, NoResult},
    '{16'd9,     1'b0, NoResult},
    '{16'd25,    1'b0, NoResult},
    '{16'd49,    1'b0, NoResult},
    '{16'd961,   1'b0, NoResult},
    '{16'd65025, 1'b0, NoResult},
    '{16'd57121, 1'b0, NoResult},
    '{16'd4,     1'b0, NoResult},
    '{16'd6,     1'b0, NoResult},
    '{16'd15,    1'b0, NoResult},
    '{16'd45,    1'b0, NoResult},
    '{16'h5555,  1'b0, NoResult},
    '{16'hAAAA,  1'b0, NoResult},
    '{16'd1023,  1'b0, NoResult},
    '{16'd30030, 1'b0, NoResult}
  };

  // These values are sent while the receiver holds off. The first one alone
  // gives 15 results, so the block must fill up and stop taking requests.
  logic [tdf_pkg::ValueFieldWidth-1:0] crowding_values [0:NumCrowding-1] =
    '{16'd32768, 16'd30030, 16'd12, 16'd64};

  int unsigned small_primes [0:7] = '{2, 3, 5, 7, 11, 13, 17, 19};

  logic clk_i = 1'b0;
  logic rst_ni;

  tdf_in_if  req_if ();
  tdf_out_if res_if ();

  trial_division_factorizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Results still owed by the block, oldest first.
  factor_result_t awaited_factors [$];
  // The results of one request, as the predictor works them out.
  factor_result_t predicted_factors [$];

  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          calm_phase;
  bit          long_hold_due;

  // First strip the twos. Then divide out each odd divisor as often as it
  // divides, while d*d <= n. A cofactor above two that is left at the end is
  // the largest prime factor. The final result of the request carries last.
  task automatic factorize_value(input logic [tdf_pkg::ValueFieldWidth-1:0] value);
    int unsigned    n;
    int unsigned    d;
    int unsigned    idx;
    factor_result_t entry;
    predicted_factors.delete();
    n = 32'(value);
    d = 0;
    if (n < 2) begin
      predicted_factors.insert(predicted_factors.size(),
                               '{factor: '0, has_factor: 1'b0, last: 1'b1});
    end else begin
      while ((n % 2) == 0 && predicted_factors.size() < tdf_pkg::MaxResults) begin
        predicted_factors.insert(predicted_factors.size(),
                                 '{factor: 16'd2, has_factor: 1'b1, last: 1'b0});
        n = n / 2;
      end
      d = 3;
      while (d * d <= n && predicted_factors.size() < tdf_pkg::MaxResults) begin
        if ((n % d) == 0) begin
          predicted_factors.insert(predicted_factors.size(),
                                   '{factor: d[tdf_pkg::FactorFieldWidth-1:0],
                                     has_factor: 1'b1, last: 1'b0});
          n = n / d;
        end else begin
          d = d + 2;
        end
      end
      if (n > 2 && predicted_factors.size() < tdf_pkg::MaxResults) begin
        predicted_factors.insert(predicted_factors.size(),
                                 '{factor: n[tdf_pkg::FactorFieldWidth-1:0],
                                   has_factor: 1'b1, last: 1'b0});
      end
      idx = predicted_factors.size() - 1;
      entry = predicted_factors[idx];
      entry.last = 1'b1;
      predicted_factors[idx] = entry;
    end
  endtask

  // Offer one request and wait for its handshake. Before the request, the valid
  // line may drop for a short burst. After the handshake, the task returns at
  // the next falling edge and drives nothing there. That way the next request
  // can keep valid high with a single assignment in that time step.
  task automatic offer_value(input logic [tdf_pkg::ValueFieldWidth-1:0] value,
                             input logic typed_in, input factor_result_t outcome);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    factorize_value(value);
    if (typed_in) begin
      awaited_factors.insert(awaited_factors.size(), outcome);
    end else begin
      foreach (predicted_factors[k]) begin
        awaited_factors.insert(awaited_factors.size(), predicted_factors[k]);
      end
    end
    @(negedge clk_i);
  endtask

  // Draw a random value. The largest share of draws are products of small
  // primes, which give long runs of results. Squares of odd numbers test where
  // the search stops. Full-range and near-top values can take long searches,
  // and a few tiny values hit the case below two.
  function automatic logic [tdf_pkg::ValueFieldWidth-1:0] draw_value();
    int unsigned v;
    int unsigned p;
    int unsigned d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = 1;
        repeat ($urandom_range(1, 14)) begin
          p = small_primes[$urandom_range(0, 7)];
          if (v * p <= 65535) v = v * p;
        end
      end
      4, 5, 6: v = $urandom_range(0, 65535);
      7:       v = $urandom_range(0, 31);
      8: begin
        d = 2 * $urandom_range(1, 127) + 1;
        v = d * d;
        if ($urandom_range(0, 1) == 1 && v * 2 <= 65535) v = v * 2;
      end
      default: v = $urandom_range(60000, 65535);
    endcase
    return v[tdf_pkg::ValueFieldWidth-1:0];
  endfunction

  // Receiver. Ready changes only at falling edges. Short random stalls are
  // mixed with runs of plain acceptance, and there are none in the calm tail.
  // When the main process asks for it, ready is held low for one long hold.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor. Each accepted result is compared with the oldest owed one.
  // A result that arrives when nothing is owed is an error too.
  always @(posedge clk_i) begin : check_results
    factor_result_t seen;
    factor_result_t due;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = '{factor: res_if.factor, has_factor: res_if.has_factor, last: res_if.last};
      if (awaited_factors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: factor %0d has_factor %0b last %0b",
                   seen.factor, seen.has_factor, seen.last);
        end
      end else begin
        due = awaited_factors.pop_front();
        if (seen.factor !== due.factor || seen.has_factor !== due.has_factor ||
            seen.last !== due.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     due.factor, due.has_factor, due.last,
                     seen.factor, seen.has_factor, seen.last);
          end
        end
      end
    end
  end

  // Watchdog. It counts cycles in which neither side completes a handshake.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("trial_division_factorizer_test: errors");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
    calm_phase     = 1'b0;
    long_hold_due  = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.value = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (directed_vectors[i]) begin
      offer_value(directed_vectors[i].value, directed_vectors[i].typed_in,
                  directed_vectors[i].outcome);
    end

    // Back pressure. The receiver stalls for a long stretch while requests
    // keep coming.
    long_hold_due = 1'b1;
    foreach (crowding_values[i]) offer_value(crowding_values[i], 1'b0, NoResult);

    // Random requests. The last few run with no idle cycles on either side.
    for (int unsigned i = 0; i < RandomValues; i++) begin
      if (i == RandomValues - CalmValues) calm_phase = 1'b1;
      offer_value(draw_value(), 1'b0, NoResult);
    end
    req_if.valid <= 1'b0;

    // Let every owed result drain. The watchdog covers a hang.
    while (awaited_factors.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_factors.size() == 0) begin
      $display("trial_division_factorizer_test: clean");
    end else begin
      $display("trial_division_factorizer_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tdf_pkg.sv
rtl/core/tdf_in_if.sv
rtl/core/tdf_out_if.sv
rtl/core/trial_division_factorizer.sv
bench/trial_division_factorizer_test.sv
